// ===== sv/bbpa_pkg.sv =====
// Package for the bitmap block pool allocator.
// Holds status and opcode codes, controller states and the command/status bundles.
// No dependencies; the controller, datapath and top level import it.
package bbpa_pkg;

   // Result status codes
   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOFREE   = 2'd1,
      ST_RANGE    = 2'd2,
      ST_NOTALLOC = 2'd3
   } bbpa_status_type;

   // Request opcodes
   typedef enum logic {
      OP_ALLOC = 1'b0,
      OP_FREE  = 1'b1
   } bbpa_op_type;

   // Configuration register indexes (word address bits of paddr)
   localparam logic [1:0] REG_BASE_ADDRESS    = 2'd0;
   localparam logic [1:0] REG_BLOCK_SIZE_LOG2 = 2'd1;
   localparam logic [1:0] REG_POOL_BLOCKS     = 2'd2;

   localparam int PADDR_W = 4;

   // Controller states
   typedef enum logic [3:0] {
      S_IDLE,
      S_ALLOC_READ,
      S_ALLOC_CHECK,
      S_ALLOC_GRANT,
      S_FREE_OFFSET,
      S_FREE_INDEX,
      S_FREE_SEEK,
      S_FREE_CHECK,
      S_DONE
   } bbpa_state_type;

   // Controller to datapath commands
   typedef struct packed {
      logic            capture;
      logic            mem_read;
      logic            advance;
      logic            set_bit;
      logic            clear_bit;
      logic            calc_offset;
      logic            calc_index;
      logic            grant_calc;
      logic            result_load;
      bbpa_status_type result_code;
      logic            out_load;
   } bbpa_cmd_type;

   // Datapath to controller status
   typedef struct packed {
      logic scan_done;
      logic found;
      logic in_range;
      logic word_hit;
      logic bit_set;
      logic out_free;
   } bbpa_stat_type;

endpackage

// ===== sv/bbpa_req_if.sv =====
// Request channel of the bitmap block pool allocator.
// Carries valid/ready and the request payload; no dependencies.
interface bbpa_req_if;
   logic        valid;
   logic        ready;
   logic        opcode;
   logic [31:0] block_address;

   modport source (output valid, output opcode, output block_address, input ready);
   modport sink   (input valid, input opcode, input block_address, output ready);
endinterface

// ===== sv/bbpa_rsp_if.sv =====
// Response channel of the bitmap block pool allocator.
// Carries valid/ready and the result payload; no dependencies.
interface bbpa_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [31:0] granted_address;

   modport source (output valid, output status, output granted_address, input ready);
   modport sink   (input valid, input status, input granted_address, output ready);
endinterface

// ===== sv/bbpa_ctrl.sv =====
// Controller of the bitmap block pool allocator: sequences allocate and free.
// Depends on bbpa_pkg for states and the command/status bundles.
module bbpa_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_is_free,
   output logic                  req_ready,
   input  bbpa_pkg::bbpa_stat_type stat,
   output bbpa_pkg::bbpa_cmd_type  cmd
);
   import bbpa_pkg::*;

   bbpa_state_type state_ff;
   bbpa_state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = req_is_free ? S_FREE_OFFSET : S_ALLOC_READ;
            end
         end
         S_ALLOC_READ: begin
            if (stat.scan_done) begin
               cmd.result_load = 1'b1;
               cmd.result_code = ST_NOFREE;
               state_in        = S_DONE;
            end else begin
               cmd.mem_read = 1'b1;
               state_in     = S_ALLOC_CHECK;
            end
         end
         S_ALLOC_CHECK: begin
            if (stat.found) begin
               cmd.set_bit = 1'b1;
               state_in    = S_ALLOC_GRANT;
            end else begin
               cmd.advance = 1'b1;
               state_in    = S_ALLOC_READ;
            end
         end
         S_ALLOC_GRANT: begin
            cmd.grant_calc = 1'b1;
            state_in       = S_DONE;
         end
         S_FREE_OFFSET: begin
            cmd.calc_offset = 1'b1;
            state_in        = S_FREE_INDEX;
         end
         S_FREE_INDEX: begin
            cmd.calc_index = 1'b1;
            if (stat.in_range) begin
               state_in = S_FREE_SEEK;
            end else begin
               cmd.result_load = 1'b1;
               cmd.result_code = ST_RANGE;
               state_in        = S_DONE;
            end
         end
         S_FREE_SEEK: begin
            if (stat.word_hit) begin
               cmd.mem_read = 1'b1;
               state_in     = S_FREE_CHECK;
            end else begin
               cmd.advance = 1'b1;
            end
         end
         S_FREE_CHECK: begin
            cmd.result_load = 1'b1;
            if (stat.bit_set) begin
               cmd.clear_bit   = 1'b1;
               cmd.result_code = ST_OK;
            end else begin
               cmd.result_code = ST_NOTALLOC;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ===== sv/bbpa_datapath.sv =====
// Datapath of the bitmap block pool allocator: bitmap memory, word scan,
// address arithmetic, result and output registers. Depends on bbpa_pkg.
module bbpa_datapath #(
   parameter int MAP_WORDS = 8,
   parameter int WORD_BITS = 32
) (
   input  logic                    clock,
   input  logic                    reset,
   input  bbpa_pkg::bbpa_cmd_type  cmd,
   output bbpa_pkg::bbpa_stat_type stat,
   input  logic [31:0]             base_address,
   input  logic [3:0]              block_size_log2,
   input  logic [8:0]              pool_blocks,
   input  logic [31:0]             req_block_address,
   input  logic                    rsp_ready,
   output logic                    rsp_valid,
   output logic [1:0]              rsp_status,
   output logic [31:0]             rsp_granted_address
);
   import bbpa_pkg::*;

   localparam int CAPACITY = MAP_WORDS * WORD_BITS;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int WADDR_W  = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
   localparam int BIT_W    = $clog2(WORD_BITS);

   // Bitmap storage; a word never written reads as all free
   logic [WORD_BITS-1:0] bitmap_mem [MAP_WORDS];
   logic [MAP_WORDS-1:0] map_valid_ff;

   logic [31:0]          addr_ff;
   logic [31:0]          off_ff;
   logic [CNT_W-1:0]     idx_ff;
   logic [WADDR_W-1:0]   word_ptr_ff;
   logic [CNT_W-1:0]     word_base_ff;
   logic [CNT_W-1:0]     rem_ff;
   logic [WORD_BITS-1:0] rd_data_ff;
   logic                 rd_valid_ff;
   logic [CNT_W-1:0]     grant_idx_ff;
   bbpa_status_type      res_status_ff;
   logic [31:0]          res_addr_ff;
   logic                 out_valid_ff;
   logic [1:0]           out_status_ff;
   logic [31:0]          out_addr_ff;

   logic [CNT_W-1:0]     limit;
   logic [WORD_BITS-1:0] cur_word;
   logic [WORD_BITS-1:0] free_vec;
   logic                 found;
   logic [BIT_W-1:0]     pos;
   logic [BIT_W-1:0]     bit_pos;
   logic [31:0]          idx_wide;
   logic [CNT_W:0]       word_end;
   logic                 wr_en;
   logic [WORD_BITS-1:0] wr_data;

   // Usable pool size: the smaller of the register and the bitmap capacity
   assign limit = (32'(pool_blocks) > 32'(CAPACITY)) ? CNT_W'(CAPACITY)
                                                     : CNT_W'(pool_blocks);

   assign cur_word = rd_valid_ff ? rd_data_ff : '0;

   // Lowest clear bit of the current word that still lies inside the pool
   always_comb begin
      found = 1'b0;
      pos   = '0;
      for (int j = 0; j < WORD_BITS; j++) begin
         free_vec[j] = !cur_word[j] && (CNT_W'(j) < rem_ff);
      end
      for (int j = WORD_BITS - 1; j >= 0; j--) begin
         if (free_vec[j]) begin
            found = 1'b1;
            pos   = BIT_W'(j);
         end
      end
   end

   // Free path: block index and its place in the current word
   assign idx_wide = off_ff >> block_size_log2;
   assign word_end = {1'b0, word_base_ff} + (CNT_W + 1)'(WORD_BITS);
   assign bit_pos  = BIT_W'(idx_ff - word_base_ff);

   always_comb begin
      stat.scan_done = (word_base_ff >= limit);
      stat.found     = found;
      stat.in_range  = (idx_wide < 32'(limit));
      stat.word_hit  = ({1'b0, idx_ff} < word_end);
      stat.bit_set   = cur_word[bit_pos];
      stat.out_free  = !out_valid_ff || rsp_ready;
   end

   // Word update: set the claimed bit or clear the freed bit
   assign wr_en   = cmd.set_bit || cmd.clear_bit;
   assign wr_data = cmd.set_bit ? (cur_word | (WORD_BITS'(1) << pos))
                                : (cur_word & ~(WORD_BITS'(1) << bit_pos));

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bitmap_mem[word_ptr_ff] <= wr_data;
      end
      if (cmd.mem_read) begin
         rd_data_ff  <= bitmap_mem[word_ptr_ff];
         rd_valid_ff <= map_valid_ff[word_ptr_ff];
      end
   end

   // Written-word flags; reset marks the whole bitmap free
   always_ff @(posedge clock) begin
      if (reset) begin
         map_valid_ff <= '0;
      end else if (wr_en) begin
         map_valid_ff[word_ptr_ff] <= 1'b1;
      end
   end

   // Scan position and address arithmetic
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         addr_ff      <= req_block_address;
         word_ptr_ff  <= '0;
         word_base_ff <= '0;
      end else if (cmd.advance) begin
         word_ptr_ff  <= word_ptr_ff + WADDR_W'(1);
         word_base_ff <= word_base_ff + CNT_W'(WORD_BITS);
      end
      if (cmd.mem_read) begin
         rem_ff <= limit - word_base_ff;
      end
      if (cmd.set_bit) begin
         grant_idx_ff <= word_base_ff + CNT_W'(pos);
      end
      if (cmd.calc_offset) begin
         off_ff <= addr_ff - base_address;
      end
      if (cmd.calc_index) begin
         idx_ff <= idx_wide[CNT_W-1:0];
      end
      if (cmd.grant_calc) begin
         res_status_ff <= ST_OK;
         res_addr_ff   <= base_address + (32'(grant_idx_ff) << block_size_log2);
      end else if (cmd.result_load) begin
         res_status_ff <= cmd.result_code;
         res_addr_ff   <= '0;
      end
   end

   // Output register: hold the result until the transfer completes
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         out_status_ff <= res_status_ff;
         out_addr_ff   <= res_addr_ff;
      end
   end

   assign rsp_valid           = out_valid_ff;
   assign rsp_status          = out_status_ff;
   assign rsp_granted_address = out_addr_ff;

endmodule

// ===== sv/bitmap_block_pool_allocator.sv =====
// Top level of the bitmap block pool allocator: configuration registers,
// controller and datapath. Depends on bbpa_pkg, bbpa_req_if, bbpa_rsp_if,
// bbpa_ctrl and bbpa_datapath.
//
// Fixed-block pool allocator with one bitmap bit per block. An allocate
// claims the lowest free block below min(pool_blocks, MAP_WORDS*WORD_BITS)
// and returns base_address + (index << block_size_log2); a free maps the
// address back to an index, checks range and allocation, and clears the bit.
// One request is in flight at a time. The bitmap lives in a one-port memory of
// MAP_WORDS words read one word per access, so an allocate reads the words in
// turn until one holds a free block, or until every word that starts below
// the pool size has been read when none is free. A free steps over the words
// before the block's word, then reads that word and checks its bit; an address
// outside the pool is refused before any word is read. While the output
// register is still occupied, the finished result waits until the previous
// one has been taken. A finished result sits in an output register, so a new
// request is taken while it waits. Reset marks every block free at once;
// configuration is at 0x0 base_address, 0x4 block_size_log2, 0x8 pool_blocks
// and must be written only while the block is idle.
module bitmap_block_pool_allocator #(
   parameter int MAP_WORDS = 8,
   parameter int WORD_BITS = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   bbpa_req_if.sink                      req_bus,
   bbpa_rsp_if.source                    rsp_bus,
   input  logic                          psel,
   input  logic                          penable,
   input  logic                          pwrite,
   input  logic [bbpa_pkg::PADDR_W-1:0]  paddr,
   input  logic [31:0]                   pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);
   import bbpa_pkg::*;

   logic [31:0] base_address_ff;
   logic [3:0]  block_size_log2_ff;
   logic [8:0]  pool_blocks_ff;
   logic        csr_write;

   bbpa_cmd_type  cmd;
   bbpa_stat_type stat;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   // Configuration register writes
   always_ff @(posedge clock) begin
      if (reset) begin
         base_address_ff    <= 32'd0;
         block_size_log2_ff <= 4'd2;
         pool_blocks_ff     <= 9'd0;
      end else if (csr_write) begin
         unique case (paddr[3:2])
            REG_BASE_ADDRESS:    base_address_ff    <= pwdata;
            REG_BLOCK_SIZE_LOG2: block_size_log2_ff <= pwdata[3:0];
            REG_POOL_BLOCKS:     pool_blocks_ff     <= pwdata[8:0];
            default: begin
            end
         endcase
      end
   end

   // Configuration readback
   always_comb begin
      unique case (paddr[3:2])
         REG_BASE_ADDRESS:    prdata = base_address_ff;
         REG_BLOCK_SIZE_LOG2: prdata = {28'd0, block_size_log2_ff};
         REG_POOL_BLOCKS:     prdata = {23'd0, pool_blocks_ff};
         default:             prdata = 32'd0;
      endcase
   end

   bbpa_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_bus.valid),
      .req_is_free (req_bus.opcode == OP_FREE),
      .req_ready   (req_bus.ready),
      .stat        (stat),
      .cmd         (cmd)
   );

   bbpa_datapath #(
      .MAP_WORDS (MAP_WORDS),
      .WORD_BITS (WORD_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .stat                (stat),
      .base_address        (base_address_ff),
      .block_size_log2     (block_size_log2_ff),
      .pool_blocks         (pool_blocks_ff),
      .req_block_address   (req_bus.block_address),
      .rsp_ready           (rsp_bus.ready),
      .rsp_valid           (rsp_bus.valid),
      .rsp_status          (rsp_bus.status),
      .rsp_granted_address (rsp_bus.granted_address)
   );

`ifndef ASSERT_OFF
   // Only one request in flight: no accept in the cycle after an accept
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |=> !req_bus.ready)
      else $error("request accepted while another is in flight");

   // Failed requests carry a zero address (a successful free also returns zero)
   a_zero_address: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid && (rsp_bus.status != 2'(ST_OK)) |->
      rsp_bus.granted_address == 32'd0)
      else $error("nonzero address on a failed response");

   // A result is moved to the output only when the output slot is free
   a_out_load_free: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> stat.out_free)
      else $error("output register overwritten");

   // No bitmap update while a new request is being taken
   a_no_write_on_accept: assert property (@(posedge clock) disable iff (reset)
      req_bus.valid && req_bus.ready |-> !(cmd.set_bit || cmd.clear_bit))
      else $error("bitmap written during request accept");
`endif

endmodule
